// ----- rtl/core/bbd_pkg.sv -----
// Shared types and helpers for the Bayer bilinear demosaic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbd_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int ROW_BITS    = 14;
    localparam int SUM_BITS    = 10;
    localparam int DIV3_MUL    = 683;
    localparam int DIV3_SHIFT  = 11;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [2:0][2:0] t_win;   // [row][col], col 2 is newest

    typedef struct packed {
        logic has_top;
        logic has_bot;
        logic has_left;
        logic has_right;
        logic row_odd;
        logic col_odd;
    } t_site;

    // Floored mean of up to four samples.
    function automatic t_sample avg(input logic [SUM_BITS-1:0] sum, input logic [2:0] n);
        logic [SUM_BITS+DIV3_SHIFT-1:0] prod;
        t_sample                        res;
        prod = {{DIV3_SHIFT{1'b0}}, sum} * (SUM_BITS+DIV3_SHIFT)'(DIV3_MUL);
        case (n)
            3'd1:    res = sum[SAMPLE_BITS-1:0];
            3'd2:    res = sum[SAMPLE_BITS:1];
            3'd3:    res = prod[DIV3_SHIFT +: SAMPLE_BITS];
            3'd4:    res = sum[SAMPLE_BITS+1:2];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bbd_interp.sv -----
// Color reconstruction for one site from the 3x3 window.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbd_interp (
    input  wire bbd_pkg::t_win    i_win,
    input  wire bbd_pkg::t_site   i_site,
    output bbd_pkg::t_sample      o_red,
    output bbd_pkg::t_sample      o_green,
    output bbd_pkg::t_sample      o_blue
);
    logic [bbd_pkg::SUM_BITS-1:0] vs, hs, ds, cs;
    logic [2:0]                   vn, hn, dn, cn;
    bbd_pkg::t_sample             vert, horz, crs, diag, ctr;
    logic tl, tr, bl, br;

    always_comb begin
        tl = i_site.has_top & i_site.has_left;
        tr = i_site.has_top & i_site.has_right;
        bl = i_site.has_bot & i_site.has_left;
        br = i_site.has_bot & i_site.has_right;
        vs = (i_site.has_top ? 10'(i_win[0][1]) : '0) + (i_site.has_bot ? 10'(i_win[2][1]) : '0);
        vn = 3'(i_site.has_top) + 3'(i_site.has_bot);
        hs = (i_site.has_left ? 10'(i_win[1][0]) : '0)
           + (i_site.has_right ? 10'(i_win[1][2]) : '0);
        hn = 3'(i_site.has_left) + 3'(i_site.has_right);
        ds = (tl ? 10'(i_win[0][0]) : '0) + (tr ? 10'(i_win[0][2]) : '0)
           + (bl ? 10'(i_win[2][0]) : '0) + (br ? 10'(i_win[2][2]) : '0);
        dn = 3'(tl) + 3'(tr) + 3'(bl) + 3'(br);
        cs = vs + hs;
        cn = vn + hn;
        vert = bbd_pkg::avg(vs, vn);
        horz = bbd_pkg::avg(hs, hn);
        crs  = bbd_pkg::avg(cs, cn);
        diag = bbd_pkg::avg(ds, dn);
        ctr  = i_win[1][1];
        case ({i_site.row_odd, i_site.col_odd})
            2'b00: begin
                o_red = vert; o_green = ctr; o_blue = horz;
            end
            2'b01: begin
                o_red = diag; o_green = crs; o_blue = ctr;
            end
            2'b10: begin
                o_red = ctr; o_green = crs; o_blue = diag;
            end
            default: begin
                o_red = horz; o_green = ctr; o_blue = vert;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/bayer_bilinear_demosaic.sv -----
// Top level of the GBRG Bayer bilinear demosaic: line memory, window, counters.
// Depends on bbd_pkg and bbd_interp.
`timescale 1ns / 1ps
`default_nettype none
// One beat in, at most one RGB pixel out, one beat per clock sustained unless the output stalls.
// The pixel for a site passes the window register, then the output register,
// after the beat that completes its window; the two line stores share one
// synchronous memory of MAX_WIDTH x 16 bits, read ahead at the next column
// and written at the current one, with forwarding on an address match. After
// the last sample of a frame, W+1 drain beats (tuser = 1, or any beat) flush
// the last row; the last carries tlast.
module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,    // [7:0] sample
    input  wire         i_s_tuser,    // cmd
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic        o_m_tlast,    // frame_end
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [13:0] i_cfg_data
);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int RB    = bbd_pkg::ROW_BITS;
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    logic [WB-1:0] r_w;
    logic [RB-1:0] r_h;
    logic [13:0]   wv;

    always_comb begin
        wv = {2'b0, i_cfg_data[11:0]};
        if (wv < 14'd2) wv = 14'd2;
        if (wv > 14'(MAX_WIDTH)) wv = 14'(MAX_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WB'(W_RST);
            r_h <= RB'(480);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) r_w <= WB'(wv);
            else r_h <= (i_cfg_data < 14'd2) ? RB'(2) : i_cfg_data;
        end
    end

    logic [CB-1:0] r_col, n_col, r_ocol, n_ocol;
    logic [RB-1:0] r_row, n_row, r_orow, n_orow;
    bbd_pkg::t_win r_win, n_win;
    bbd_pkg::t_site r_site, n_site;
    logic r_pv, n_pv, r_ov;
    logic r_pend, n_pend;

    logic [15:0] mem [MAX_WIDTH];
    logic [15:0] r_rd, r_fwd_d, rd;
    logic        r_fwd, we;
    logic [15:0] wd;
    logic [CB-1:0] ra;

    logic en, acc, drain, emit, fend;
    bbd_pkg::t_sample top, mid, s;

    assign en         = !r_ov || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;
    assign rd         = r_fwd ? r_fwd_d : r_rd;
    assign top        = rd[15:8];
    assign mid        = rd[7:0];
    assign s          = i_s_tdata;
    assign drain      = {1'b0, r_row} >= {1'b0, r_h};

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ocol = r_ocol;
        n_orow = r_orow;
        n_win  = r_win;
        n_site = r_site;
        n_pv   = 1'b0;
        n_pend = 1'b0;
        we     = 1'b0;
        wd     = {mid, s};
        emit   = 1'b0;
        fend   = 1'b0;
        if (acc) begin
            if (drain) begin
                n_win = {8'd0, r_win[2][2:1], mid, r_win[1][2:1], top, r_win[0][2:1]};
                if ({1'b0, r_col} + 1'b1 < WB'(r_w)) n_col = r_col + 1'b1;
                emit = 1'b1;
            end else if (!i_s_tuser) begin
                we    = 1'b1;
                n_win = {s, r_win[2][2:1], mid, r_win[1][2:1], top, r_win[0][2:1]};
                if (WB'({1'b0, r_col} + 1'b1) >= r_w) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
                emit = (r_row >= RB'(1) && r_col != '0) || r_row >= RB'(2);
            end
        end
        if (emit) begin
            n_pv = 1'b1;
            n_site.has_top   = r_orow != '0;
            n_site.has_bot   = ({1'b0, r_orow} + 1'b1) < {1'b0, r_h};
            n_site.has_left  = r_ocol != '0;
            n_site.has_right = WB'({1'b0, r_ocol} + 1'b1) < r_w;
            n_site.row_odd   = r_orow[0];
            n_site.col_odd   = r_ocol[0];
            fend = !n_site.has_bot && !n_site.has_right;
            n_pend = fend;
            if (fend) begin
                n_col = '0; n_row = '0; n_ocol = '0; n_orow = '0;
            end else if (!n_site.has_right) begin
                n_ocol = '0;
                if (r_orow != RB'(16383)) n_orow = r_orow + 1'b1;
            end else begin
                n_ocol = r_ocol + 1'b1;
            end
        end
        ra = i_rst_n ? n_col : '0;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[r_col] <= wd;
        r_rd    <= mem[ra];
        r_fwd   <= we && (ra == r_col);
        r_fwd_d <= wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_win  <= '0;
            r_site <= '0;
            r_pv   <= 1'b0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            r_win  <= n_win;
            r_site <= n_site;
            r_pv   <= n_pv;
            r_pend <= n_pend;
            r_ov   <= r_pv;
        end
    end

    bbd_pkg::t_sample red, green, blue;

    bbd_interp u_interp (
        .i_win   (r_win),
        .i_site  (r_site),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_tdata <= {blue, green, red};
            o_m_tlast <= r_pend;
        end
    end

    assign o_m_tvalid = r_ov;
endmodule
`default_nettype wire

// ----- rtl/core/bbd_checker.sv -----
// Port-level checks for bayer_bilinear_demosaic, bound to the top level.
// Depends on bayer_bilinear_demosaic ports only.
`timescale 1ns / 1ps
`default_nettype none
module bbd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [23:0] o_m_tdata,
    input wire        o_m_tlast
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // a new output beat follows the input beat that made it, through the window register, then the output register
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("output without input");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled beat changed");
endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
